@@ rtl/core/mcts_pkg.sv @@
package mcts_pkg;

   // chain and table geometry
   localparam int MAX_STATES     = 16;
   localparam int PROB_FRAC_BITS = 16;
   localparam int STATE_W        = 4;
   localparam int PROB_W         = 17;
   localparam int OPCODE_W       = 2;
   localparam int NUM_STATES_W   = 5;
   localparam int TABLE_DEPTH    = MAX_STATES * MAX_STATES;
   localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
   localparam int COL_W          = $clog2(MAX_STATES);
   localparam int WALK_W         = $clog2(MAX_STATES + 1);
   localparam int CUM_W          = PROB_W + COL_W;

   // generator x = (x * MUL + ADD) mod (2^31 - 1)
   localparam int LCG_W                 = 31;
   localparam logic [LCG_W-1:0] LCG_MUL  = 31'd1103515245;
   localparam logic [LCG_W-1:0] LCG_ADD  = 31'd12345;
   localparam logic [LCG_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
   localparam logic [LCG_W-1:0] LCG_SEED = 31'd42;
   localparam int PROD_W                = 2 * LCG_W;
   localparam int FOLD_W                = LCG_W + 2;
   localparam int CMP_W                 = CUM_W + LCG_W;

   // opcodes of an input item
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_NUM_STATES = 1'd0;
   localparam logic [NUM_STATES_W-1:0] NUM_STATES_RESET = 5'd16;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_START = 2'd1,
      KIND_STEP  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [TABLE_AW-1:0]      addr;
      logic [PROB_W-1:0]        prob;
      logic [STATE_W-1:0]       state;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic [QCNT_W-1:0] level;
   } front_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

endpackage

@@ rtl/core/mcts_if.sv @@
interface mcts_req_if import mcts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [3:0]          row;
   logic [3:0]          column;
   logic [PROB_W-1:0]   probability;
   logic [3:0]          start_state;

   modport source (output valid, opcode, row, column, probability, start_state,
                   input ready);
   modport sink (input valid, opcode, row, column, probability, start_state,
                 output ready);
endinterface

interface mcts_rsp_if import mcts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] visited_state;

   modport source (output valid, visited_state, input ready);
   modport sink (input valid, visited_state, output ready);
endinterface

@@ rtl/core/markov_chain_trajectory_sampler.sv @@
// Channel   Direction  Ports           Payload
// -------   ---------  -----           -------
// request   in         req_if (sink)   opcode, row, column, probability, start_state
// result    out        rsp_if (source) visited_state
// config    in         psel .. pready  num_states at byte address 0
//
// A table write or a start is done by the back end from its idle state; a step
// runs a multiply, two reduction steps (fold, mod), then one table read per column
// of the row walk, up to min(num_states, 16) columns, on the single-port table RAM.
// Reset is synchronous: state 0, generator 42, num_states 16; table undefined.
// A step waits in the queue while the result register holds an untaken item;
// the two-entry queue keeps accepting requests while the back end works, until full.
module markov_chain_trajectory_sampler import mcts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mcts_req_if.sink              req_if,
   mcts_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [NUM_STATES_W-1:0] num_states_ff, num_states_in;
   logic [CSR_IDX_W-1:0]    csr_idx;
   logic                    csr_wr;
   queue_head_type          head;
   front_status_type        front_status;
   back_status_type         back_status;

   // register port
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      num_states_in = num_states_ff;
      if (csr_wr && (csr_idx == CSR_IDX_NUM_STATES)) begin
         num_states_in = pwdata[NUM_STATES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= NUM_STATES_RESET;
      end else begin
         num_states_ff <= num_states_in;
      end
   end

   assign prdata = (csr_idx == CSR_IDX_NUM_STATES) ? CSR_DATA_W'(num_states_ff) : '0;

   mcts_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .pop    (back_status.pop),
      .head   (head),
      .status (front_status)
   );

   mcts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .num_states (num_states_ff),
      .status     (back_status),
      .rsp        (rsp_if)
   );

   // queue never overfills
   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      front_status.level <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue over its depth");

   // no command leaves the queue while a step is in progress
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !back_status.pop)
      else $error("pop while back end busy");

   // every step that leaves the queue shows its result in the next cycle
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      (back_status.pop && head.entry.kind == KIND_STEP) |=> rsp_if.valid)
      else $error("step without result");

endmodule

@@ rtl/core/mcts_ram.sv @@
module mcts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write through the single port, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mcts_front.sv @@
module mcts_front import mcts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mcts_req_if.sink         req,
   input  logic             pop,
   output queue_head_type   head,
   output front_status_type status
);

   entry_type         queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] level_ff, level_in;
   logic              accept;
   logic              keep;
   logic              push;
   entry_type         entry;

   assign req.ready = (level_ff < QCNT_W'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;

   // classify the item: drop unknown opcodes and writes outside the table
   always_comb begin
      entry.kind  = KIND_STEP;
      entry.addr  = TABLE_AW'(int'(req.row) * MAX_STATES + int'(req.column));
      entry.prob  = req.probability;
      entry.state = (int'(req.start_state) < MAX_STATES) ? req.start_state : '0;
      keep        = 1'b0;
      case (req.opcode)
         OP_WRITE: begin
            entry.kind = KIND_WRITE;
            keep = (int'(req.row) < MAX_STATES) && (int'(req.column) < MAX_STATES);
         end
         OP_START: begin
            entry.kind = KIND_START;
            keep = 1'b1;
         end
         OP_STEP: begin
            entry.kind = KIND_STEP;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = accept && keep;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = QCNT_W'(level_ff + 1'b1);
      end else if (!push && pop) begin
         level_in = QCNT_W'(level_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign head.valid   = (level_ff != '0);
   assign head.entry   = queue_ff[rd_ptr_ff];
   assign status.level = level_ff;

endmodule

@@ rtl/core/mcts_back.sv @@
module mcts_back import mcts_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  queue_head_type          head,
   input  logic [NUM_STATES_W-1:0] num_states,
   output back_status_type         status,
   mcts_rsp_if.source              rsp
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FOLD = 4'b0010,
      ST_MOD  = 4'b0100,
      ST_WALK = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [STATE_W-1:0]   cur_ff, cur_in;
   logic [LCG_W-1:0]     rng_ff, rng_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [FOLD_W-1:0]    fold_ff, fold_in;
   logic [CUM_W-1:0]     cum_ff, cum_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]   rsp_state_ff, rsp_state_in;

   logic                 pop;
   logic                 slot_free;
   logic [WALK_W-1:0]    walk;
   logic [TABLE_AW-1:0]  base;
   logic [TABLE_AW-1:0]  ram_addr;
   logic                 ram_we;
   logic [PROB_W-1:0]    ram_rdata;
   logic [FOLD_W-1:0]    sum_mod;
   logic [CMP_W-1:0]     lhs_sum;
   logic [CMP_W-1:0]     rhs;
   logic                 hit;
   logic                 last_col;

   mcts_ram #(
      .WIDTH (PROB_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (head.entry.prob),
      .rd_data (ram_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign walk      = (int'(num_states) > MAX_STATES) ? WALK_W'(MAX_STATES)
                                                      : WALK_W'(num_states);
   assign base      = TABLE_AW'(int'(cur_ff) * MAX_STATES);

   // second fold of the Mersenne reduction and final correction
   always_comb begin
      sum_mod = FOLD_W'(fold_ff[LCG_W-1:0]) + FOLD_W'(fold_ff[FOLD_W-1:LCG_W]);
      if (sum_mod >= FOLD_W'(LCG_MOD)) begin
         sum_mod = FOLD_W'(sum_mod - FOLD_W'(LCG_MOD));
      end
   end

   // row walk: x << FRAC <= cum * (2^31 - 1)  <=>  (x << FRAC) + cum <= cum << 31
   always_comb begin
      lhs_sum  = CMP_W'({rng_ff, {PROB_FRAC_BITS{1'b0}}}) + CMP_W'(cum_ff + CUM_W'(ram_rdata));
      rhs      = {CUM_W'(cum_ff + CUM_W'(ram_rdata)), {LCG_W{1'b0}}};
      hit      = (CUM_W'(cum_ff + CUM_W'(ram_rdata)) >= CUM_W'(1 << PROB_FRAC_BITS))
                 || (lhs_sum <= rhs);
      last_col = ((WALK_W'(col_ff) + WALK_W'(1)) >= walk);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rng_in       = rng_ff;
      prod_in      = prod_ff;
      fold_in      = fold_ff;
      cum_in       = cum_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_state_in = rsp_state_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = head.entry.addr;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               case (head.entry.kind)
                  KIND_WRITE: begin
                     pop    = 1'b1;
                     ram_we = 1'b1;
                  end
                  KIND_START: begin
                     pop    = 1'b1;
                     cur_in = head.entry.state;
                     rng_in = LCG_SEED;
                  end
                  KIND_STEP: begin
                     if (slot_free) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_state_in = cur_ff;
                        prod_in      = PROD_W'(rng_ff) * PROD_W'(LCG_MUL);
                        state_in     = ST_FOLD;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_FOLD: begin
            // add the increment and fold the high half onto the low half
            fold_in  = FOLD_W'(prod_ff[LCG_W-1:0]) + FOLD_W'(prod_ff[PROD_W-1:LCG_W])
                       + FOLD_W'(LCG_ADD);
            state_in = ST_MOD;
         end
         ST_MOD: begin
            rng_in   = sum_mod[LCG_W-1:0];
            cum_in   = '0;
            col_in   = '0;
            ram_addr = base;
            state_in = (walk == '0) ? ST_IDLE : ST_WALK;
         end
         ST_WALK: begin
            cum_in   = CUM_W'(cum_ff + CUM_W'(ram_rdata));
            col_in   = COL_W'(col_ff + 1'b1);
            ram_addr = TABLE_AW'(base + TABLE_AW'(col_in));
            if (hit) begin
               cur_in   = STATE_W'(col_ff);
               state_in = ST_IDLE;
            end else if (last_col) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         rng_ff       <= LCG_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rng_ff       <= rng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      fold_ff      <= fold_in;
      cum_ff       <= cum_in;
      col_ff       <= col_in;
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.visited_state = rsp_state_ff;
   assign status.busy       = (state_ff != ST_IDLE);
   assign status.pop        = pop;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import mcts_pkg::*;

   localparam logic [OPCODE_W-1:0]   OP_UNUSED      = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] NUM_STATES_ADDR = {CSR_IDX_NUM_STATES, 2'b00};
   localparam int TOTAL_ITEMS   = 1700;
   localparam int QUIET_FROM    = TOTAL_ITEMS - 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int ROW_EXACT     = 0;
   localparam int ROW_SHORT     = 1;
   localparam int ROW_WILD      = 2;

   typedef struct {
      bit                      cfg;
      logic [NUM_STATES_W-1:0] cfg_value;
      logic [OPCODE_W-1:0]     opcode;
      logic [3:0]              row;
      logic [3:0]              column;
      logic [PROB_W-1:0]       probability;
      logic [3:0]              start_state;
      bit                      typed;
      logic [STATE_W-1:0]      visited;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mcts_req_if req_bus ();
   mcts_rsp_if rsp_bus ();

   // chain shadow: table, state, generator and walk length
   bit [PROB_W-1:0]       prob_table [MAX_STATES][MAX_STATES];
   bit [STATE_W-1:0]      chain_state;
   bit [LCG_W-1:0]        lcg_value;
   bit [NUM_STATES_W-1:0] walk_length;

   logic [STATE_W-1:0] visited_expected [$];
   plan_row_type       directed_plan [$];
   int                 error_count;
   int                 items_sent;
   int                 hold_cycles;
   bit                 idle_on;

   markov_chain_trajectory_sampler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("markov_chain_trajectory_sampler: mismatch");
      $finish;
   end

   task automatic report(input string msg);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // apply one accepted item to the shadow chain
   function automatic void advance_chain(input logic [OPCODE_W-1:0] op,
                                         input logic [3:0] row, input logic [3:0] column,
                                         input logic [PROB_W-1:0] prob,
                                         input logic [3:0] start,
                                         output bit emits, output logic [STATE_W-1:0] visited);
      int                 walk;
      bit [63:0]          lhs;
      bit [63:0]          cum;
      bit [STATE_W-1:0]   next;
      bit                 found;
      emits   = 1'b0;
      visited = chain_state;
      case (op)
         OP_WRITE: prob_table[row][column] = prob;
         OP_START: begin
            chain_state = start;
            lcg_value   = LCG_SEED;
         end
         OP_STEP: begin
            emits     = 1'b1;
            lcg_value = 31'((64'(lcg_value) * 64'(LCG_MUL) + 64'(LCG_ADD)) % 64'(LCG_MOD));
            lhs       = 64'(lcg_value) << PROB_FRAC_BITS;
            walk      = (walk_length < MAX_STATES) ? int'(walk_length) : MAX_STATES;
            cum       = '0;
            found     = 1'b0;
            next      = chain_state;
            // first column whose running sum covers the draw
            for (int j = 0; j < walk; j++) begin
               if (!found) begin
                  cum += 64'(prob_table[chain_state][j]);
                  if (cum >= (64'd1 << PROB_FRAC_BITS) || lhs <= cum * 64'(LCG_MOD)) begin
                     next  = 4'(j);
                     found = 1'b1;
                  end
               end
            end
            chain_state = next;
         end
         default: ;
      endcase
   endfunction

   // offer one item, hold it until taken, then predict
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [3:0] row,
                            input logic [3:0] column, input logic [PROB_W-1:0] prob,
                            input logic [3:0] start, input bit typed,
                            input logic [STATE_W-1:0] typed_state);
      int                 gap;
      bit                 emits;
      logic [STATE_W-1:0] visited;
      if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.row         <= row;
      req_bus.column      <= column;
      req_bus.probability <= prob;
      req_bus.start_state <= start;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      advance_chain(op, row, column, prob, start, emits, visited);
      if (emits) visited_expected.push_back(typed ? typed_state : visited);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // stop offering and wait for every expected item, then let the back end settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (visited_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= NUM_STATES_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // write num_states and read it back
   task automatic set_num_states(input logic [NUM_STATES_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b1, CSR_DATA_W'(value), rdata);
      walk_length = value;
      @(posedge clock);
      csr_transfer(1'b0, '0, rdata);
      if (rdata[NUM_STATES_W-1:0] !== value)
         report($sformatf("num_states read %0d, wrote %0d", rdata[NUM_STATES_W-1:0], value));
   endtask

   // load the first n columns of a row: exact rows sum to one, short rows fall short, wild rows are random
   task automatic load_row(input logic [3:0] row, input int n, input int mode);
      int                weight [MAX_STATES];
      int                total;
      int                budget;
      int                given;
      logic [PROB_W-1:0] prob;
      total = 0;
      given = 0;
      for (int j = 0; j < n; j++) begin
         weight[j] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1000);
         total += weight[j];
      end
      if (total == 0) begin
         weight[n-1] = 1;
         total       = 1;
      end
      budget = (mode == ROW_SHORT) ? $urandom_range(0, 65535) : 65536;
      for (int j = 0; j < n; j++) begin
         if (mode == ROW_WILD)
            prob = $urandom_range(0, 1) ? PROB_W'($urandom_range(0, 'h1FFFF))
                                        : PROB_W'($urandom_range(0, 8192));
         else if (j == n - 1)
            prob = PROB_W'(budget - given);
         else
            prob = PROB_W'(budget * weight[j] / total);
         given += prob;
         send_item(OP_WRITE, row, 4'(j), prob, 4'($urandom_range(0, 15)), 1'b0, '0);
      end
   endtask

   function automatic void plan_item(input logic [OPCODE_W-1:0] op, input logic [3:0] row,
                                     input logic [3:0] column, input logic [PROB_W-1:0] prob,
                                     input logic [3:0] start, input bit typed,
                                     input logic [STATE_W-1:0] visited);
      plan_row_type r;
      r.cfg         = 1'b0;
      r.cfg_value   = '0;
      r.opcode      = op;
      r.row         = row;
      r.column      = column;
      r.probability = prob;
      r.start_state = start;
      r.typed       = typed;
      r.visited     = visited;
      directed_plan.push_back(r);
   endfunction

   function automatic void plan_cfg(input logic [NUM_STATES_W-1:0] value);
      plan_row_type r;
      r           = '{default: '0};
      r.cfg       = 1'b1;
      r.cfg_value = value;
      directed_plan.push_back(r);
   endfunction

   // result side: check each taken item, stall in bursts or for a long hold
   initial begin
      int                 stall_left;
      logic [STATE_W-1:0] want;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (visited_expected.size() == 0) begin
               report($sformatf("visited_state %0d with nothing expected",
                                rsp_bus.visited_state));
            end else begin
               want = visited_expected.pop_front();
               if (rsp_bus.visited_state !== want)
                  report($sformatf("visited_state %0d, expected %0d",
                                   rsp_bus.visited_state, want));
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // request side: reset, table fill, directed plan, random phases
   initial begin
      logic [CSR_DATA_W-1:0]   rdata;
      logic [NUM_STATES_W-1:0] n;
      logic [3:0]              s;
      int                      phase;
      int                      pick;
      error_count = 0;
      items_sent  = 0;
      hold_cycles = 0;
      idle_on     = 1'b1;
      phase       = 0;
      chain_state = '0;
      lcg_value   = LCG_SEED;
      walk_length = NUM_STATES_RESET;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_WRITE;
      req_bus.row         <= '0;
      req_bus.column      <= '0;
      req_bus.probability <= '0;
      req_bus.start_state <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_transfer(1'b0, '0, rdata);
      if (rdata[NUM_STATES_W-1:0] !== NUM_STATES_RESET)
         report($sformatf("num_states after reset %0d", rdata[NUM_STATES_W-1:0]));

      // write every table entry before any step walks a row
      for (int r = 0; r < MAX_STATES; r++) load_row(4'(r), MAX_STATES, ROW_EXACT);

      // directed plan
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd0);
      plan_item(OP_STEP, 4'd15, 4'd15, 17'h1FFFF, 4'd15, 1'b0, '0);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd15, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd15);
      plan_item(OP_WRITE, 4'd15, 4'd0, 17'h10000, 4'd0, 1'b0, '0);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd15, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd15);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd0);
      // oversized first column makes state 0 absorbing
      plan_item(OP_WRITE, 4'd0, 4'd0, 17'h1FFFF, 4'd0, 1'b0, '0);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd0, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd0);
      plan_item(OP_WRITE, 4'd0, 4'd0, 17'h00000, 4'd0, 1'b0, '0);
      plan_item(OP_WRITE, 4'd15, 4'd15, 17'h1FFFF, 4'd15, 1'b0, '0);
      plan_item(OP_UNUSED, 4'd15, 4'd15, 17'h1FFFF, 4'd15, 1'b0, '0);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd0, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd0);
      plan_item(OP_UNUSED, 4'd0, 4'd0, '0, 4'd0, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b0, '0);
      // zero walk length: the state never moves
      plan_cfg(5'd0);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd5, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd5);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd5);
      // one column with zero probability: the state stays
      plan_cfg(5'd1);
      plan_item(OP_WRITE, 4'd7, 4'd0, 17'h00000, 4'd0, 1'b0, '0);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd7, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd7);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd7);
      // current state above num_states still walks its own row
      plan_cfg(5'd4);
      plan_item(OP_START, 4'd0, 4'd0, '0, 4'd10, 1'b0, '0);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b1, 4'd10);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b0, '0);
      // walk length clipped to the table size
      plan_cfg(5'd31);
      plan_item(OP_STEP, 4'd0, 4'd0, '0, 4'd0, 1'b0, '0);

      foreach (directed_plan[k]) begin
         if (directed_plan[k].cfg) begin
            drain();
            set_num_states(directed_plan[k].cfg_value);
         end else begin
            send_item(directed_plan[k].opcode, directed_plan[k].row, directed_plan[k].column,
                      directed_plan[k].probability, directed_plan[k].start_state,
                      directed_plan[k].typed, directed_plan[k].visited);
         end
      end

      // random phases, each with its own walk length
      while (items_sent < TOTAL_ITEMS) begin
         phase++;
         drain();
         n = (phase == 1) ? 5'd1 : (phase == 2) ? 5'd16 : 5'($urandom_range(1, 16));
         set_num_states(n);
         idle_on = ($urandom_range(0, 3) != 0);
         // hold the result side off long enough to back up the request side
         if (phase == 3) hold_cycles = LONG_HOLD;
         repeat ($urandom_range(3, 6)) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(2, 6))
                  send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), 17'($urandom_range(0, 'h1FFFF)),
                            4'($urandom_range(0, 15)), 1'b0, '0);
            end else begin
               s    = 4'($urandom_range(0, 15));
               pick = $urandom_range(0, 9);
               if ($urandom_range(0, 1))
                  load_row(s, int'(n), (pick < 6) ? ROW_EXACT :
                                       (pick < 8) ? ROW_SHORT : ROW_WILD);
               if ($urandom_range(0, 2) == 0)
                  load_row(4'($urandom_range(0, 15)), int'(n), ROW_EXACT);
               send_item(OP_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         17'($urandom_range(0, 'h1FFFF)), s, 1'b0, '0);
               repeat ($urandom_range(5, 30))
                  send_item(OP_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            17'($urandom_range(0, 'h1FFFF)), 4'($urandom_range(0, 15)),
                            1'b0, '0);
            end
            if ($urandom_range(0, 4) == 0) drain();
         end
      end

      drain();
      if (error_count == 0) begin
         $display("markov_chain_trajectory_sampler: match");
      end else begin
         $display("markov_chain_trajectory_sampler: mismatch");
      end
      $finish;
   end

endmodule

@@ markov_chain_trajectory_sampler.f @@
rtl/core/mcts_pkg.sv
rtl/core/mcts_if.sv
rtl/core/mcts_ram.sv
rtl/core/mcts_front.sv
rtl/core/mcts_back.sv
rtl/core/markov_chain_trajectory_sampler.sv
test/tb.sv
